/* sv/breath_cycle_sequencer_macros.svh */
// Assertion macros for the breath cycle sequencer.
// Included by the top level; depends on nothing else.
`ifndef BREATH_CYCLE_SEQUENCER_MACROS_SVH
`define BREATH_CYCLE_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/bcs_pkg.sv */
// Package for the breath cycle sequencer: phase and axis command codes,
// default widths and configuration reset values. Depends on nothing.
package bcs_pkg;

   localparam int TIME_WIDTH_DEFAULT     = 16;
   localparam int PRESSURE_WIDTH_DEFAULT = 16;
   localparam int CFG_INDEX_WIDTH        = 3;

   localparam int RISE_TIME_RESET        = 1000;
   localparam int HOLD_HIGH_RESET        = 1500;
   localparam int HOLD_LOW_RESET         = 2500;
   localparam int PRESSURE_LIMIT_RESET   = 2500;
   localparam int VOLUME_LIMIT_RESET     = 600;
   localparam int ASSIST_THRESHOLD_RESET = -30;

   typedef enum logic [3:0] {
      PH_HOMING       = 4'd0,
      PH_STOPPED      = 4'd1,
      PH_RISE_START   = 4'd2,
      PH_RISING       = 4'd3,
      PH_HOLD_START   = 4'd4,
      PH_HOLDING      = 4'd5,
      PH_EXHALE_START = 4'd6,
      PH_EXHALING     = 4'd7,
      PH_MANUAL       = 4'd8
   } phase_type;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_LOWER = 3'd1,
      CMD_RAISE = 3'd2,
      CMD_HOLD  = 3'd3,
      CMD_HOME  = 3'd4
   } cmd_type;

   typedef enum logic [CFG_INDEX_WIDTH-1:0] {
      CFG_RISE_TIME        = 3'd0,
      CFG_HOLD_HIGH        = 3'd1,
      CFG_HOLD_LOW         = 3'd2,
      CFG_PRESSURE_LIMIT   = 3'd3,
      CFG_VOLUME_LIMIT     = 3'd4,
      CFG_ASSIST_MODE      = 3'd5,
      CFG_ASSIST_THRESHOLD = 3'd6,
      CFG_THREE_AXIS       = 3'd7
   } cfg_index_type;

endpackage

/* sv/breath_cycle_sequencer.sv */
// Ventilator breath sequencer: homing, stopped, rise, hold, exhale and manual phases.
// A request is captured in the input register and its result in the result register.
// Throughput: one request per cycle unless stalled; the phase logic sits between the input
// register and the result register and updates the state in the same cycle.
// Reset is synchronous and active high; it restores homing phase and the register defaults.
// Depends on bcs_pkg and breath_cycle_sequencer_macros.svh.
`include "breath_cycle_sequencer_macros.svh"

module breath_cycle_sequencer #(
   parameter int TIME_WIDTH     = bcs_pkg::TIME_WIDTH_DEFAULT,
   parameter int PRESSURE_WIDTH = bcs_pkg::PRESSURE_WIDTH_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,

   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic                                        req_tick,
   input  logic                                        req_start_request,
   input  logic                                        req_manual_request,
   input  logic                                        req_restart,
   input  logic                                        req_axis1_homed,
   input  logic                                        req_axis2_homed,
   input  logic                                        req_axis3_homed,
   input  logic signed [PRESSURE_WIDTH-1:0]            req_pressure,
   input  logic        [15:0]                          req_volume,

   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic        [3:0]                           rsp_phase,
   output logic        [2:0]                           rsp_axis1_command,
   output logic        [2:0]                           rsp_other_axes_command,
   output logic                                        rsp_driver_enable,
   output logic                                        rsp_white_led,
   output logic                                        rsp_red_led,
   output logic                                        rsp_volume_clear,
   output logic                                        rsp_running,

   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [bcs_pkg::CFG_INDEX_WIDTH-1:0]         csr_index,
   input  logic [((PRESSURE_WIDTH > 16) ? PRESSURE_WIDTH : 16)-1:0] csr_wdata
);
   import bcs_pkg::*;

   localparam int CMP_WIDTH = (TIME_WIDTH > 16) ? TIME_WIDTH : 16;

   logic        [15:0]               rise_time_ff;
   logic        [15:0]               hold_high_ff;
   logic        [15:0]               hold_low_ff;
   logic signed [PRESSURE_WIDTH-1:0] pressure_limit_ff;
   logic        [15:0]               volume_limit_ff;
   logic                             assist_mode_ff;
   logic signed [PRESSURE_WIDTH-1:0] assist_threshold_ff;
   logic                             three_axis_ff;

   logic                             in_valid_ff;
   logic                             in_tick_ff;
   logic                             in_start_ff;
   logic                             in_manual_ff;
   logic                             in_restart_ff;
   logic                             in_homed1_ff;
   logic                             in_homed2_ff;
   logic                             in_homed3_ff;
   logic signed [PRESSURE_WIDTH-1:0] in_pressure_ff;
   logic        [15:0]               in_volume_ff;

   phase_type                        phase_ff, phase_in;
   logic        [TIME_WIDTH-1:0]     elapsed_ff, elapsed_in;
   logic                             enable_ff, enable_in;
   logic                             white_ff, white_in;
   logic                             red_ff, red_in;
   logic                             running_ff, running_in;

   logic                             rsp_valid_ff;
   cmd_type                          cmd1_ff, cmd1_in;
   cmd_type                          cmd23_ff, cmd23_in;
   logic                             vclear_ff, vclear_in;

   logic                             out_free;
   logic                             advance;
   logic                             req_accept;
   logic        [TIME_WIDTH-1:0]     elapsed_tick;
   logic        [CMP_WIDTH-1:0]      elapsed_cmp;
   logic                             rise_timeout;
   logic                             rise_limit;
   logic                             hold_done;
   logic                             exhale_done;
   logic                             assist_trigger;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   always_comb begin
      elapsed_tick = elapsed_ff;
      if (in_tick_ff && (elapsed_ff != {TIME_WIDTH{1'b1}})) begin
         elapsed_tick = elapsed_ff + 1'b1;
      end
   end

   assign elapsed_cmp    = CMP_WIDTH'(elapsed_tick);
   assign rise_timeout   = elapsed_cmp >= CMP_WIDTH'(rise_time_ff);
   assign rise_limit     = (in_pressure_ff >= pressure_limit_ff) ||
                           (in_volume_ff >= volume_limit_ff);
   assign hold_done      = elapsed_cmp >= CMP_WIDTH'(hold_high_ff);
   assign exhale_done    = elapsed_cmp >= CMP_WIDTH'(hold_low_ff);
   assign assist_trigger = (elapsed_cmp >= CMP_WIDTH'(hold_low_ff >> 1)) &&
                           (in_pressure_ff < assist_threshold_ff);

   always_comb begin
      phase_in   = phase_ff;
      elapsed_in = elapsed_tick;
      enable_in  = enable_ff;
      white_in   = white_ff;
      red_in     = red_ff;
      running_in = running_ff;
      cmd1_in    = CMD_NONE;
      cmd23_in   = CMD_NONE;
      vclear_in  = 1'b0;
      if (in_restart_ff) begin
         phase_in = PH_HOMING;
         cmd1_in  = CMD_HOME;
         cmd23_in = CMD_HOME;
      end else begin
         case (phase_ff)
            PH_STOPPED: begin
               if (in_start_ff) begin
                  enable_in  = 1'b1;
                  running_in = 1'b1;
                  phase_in   = PH_RISE_START;
                  elapsed_in = '0;
               end else begin
                  running_in = 1'b0;
               end
               if (in_manual_ff) begin
                  phase_in  = PH_MANUAL;
                  enable_in = 1'b1;
               end
            end
            PH_RISE_START: begin
               cmd1_in    = three_axis_ff ? CMD_LOWER : CMD_RAISE;
               cmd23_in   = CMD_LOWER;
               elapsed_in = '0;
               phase_in   = PH_RISING;
            end
            PH_RISING: begin
               if (rise_timeout) begin
                  white_in = 1'b0;
                  red_in   = 1'b0;
                  phase_in = PH_HOLD_START;
               end
               if (rise_limit) begin
                  phase_in = PH_HOLD_START;
               end
               if (!in_start_ff) begin
                  phase_in  = PH_STOPPED;
                  enable_in = 1'b0;
               end
            end
            PH_HOLD_START: begin
               cmd1_in    = CMD_HOLD;
               cmd23_in   = CMD_HOLD;
               elapsed_in = '0;
               phase_in   = PH_HOLDING;
            end
            PH_HOLDING: begin
               if (hold_done) begin
                  vclear_in = 1'b1;
                  phase_in  = PH_EXHALE_START;
               end
               if (!in_start_ff) begin
                  phase_in  = PH_STOPPED;
                  enable_in = 1'b0;
               end
            end
            PH_EXHALE_START: begin
               cmd1_in    = three_axis_ff ? CMD_RAISE : CMD_LOWER;
               cmd23_in   = CMD_RAISE;
               elapsed_in = '0;
               phase_in   = PH_EXHALING;
            end
            PH_EXHALING: begin
               if (assist_mode_ff) begin
                  if (assist_trigger) begin
                     elapsed_in = '0;
                     phase_in   = PH_RISE_START;
                  end
               end else if (exhale_done) begin
                  red_in     = 1'b1;
                  elapsed_in = '0;
                  phase_in   = PH_RISE_START;
               end
               if (!in_start_ff) begin
                  phase_in  = PH_STOPPED;
                  enable_in = 1'b0;
               end
            end
            PH_MANUAL: begin
               if (!in_manual_ff) begin
                  phase_in  = PH_STOPPED;
                  enable_in = 1'b0;
               end
            end
            default: begin
               // Homing, and any other code is handled as homing.
               phase_in  = PH_HOMING;
               enable_in = 1'b1;
               if (three_axis_ff) begin
                  if (in_homed1_ff && in_homed2_ff && in_homed3_ff) begin
                     phase_in = PH_STOPPED;
                  end
               end else if (in_homed1_ff) begin
                  cmd1_in  = CMD_LOWER;
                  phase_in = PH_STOPPED;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_time_ff        <= 16'(RISE_TIME_RESET);
         hold_high_ff        <= 16'(HOLD_HIGH_RESET);
         hold_low_ff         <= 16'(HOLD_LOW_RESET);
         pressure_limit_ff   <= PRESSURE_WIDTH'(PRESSURE_LIMIT_RESET);
         volume_limit_ff     <= 16'(VOLUME_LIMIT_RESET);
         assist_mode_ff      <= 1'b0;
         assist_threshold_ff <= PRESSURE_WIDTH'(ASSIST_THRESHOLD_RESET);
         three_axis_ff       <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (cfg_index_type'(csr_index))
            CFG_RISE_TIME:        rise_time_ff        <= csr_wdata[15:0];
            CFG_HOLD_HIGH:        hold_high_ff        <= csr_wdata[15:0];
            CFG_HOLD_LOW:         hold_low_ff         <= csr_wdata[15:0];
            CFG_PRESSURE_LIMIT:   pressure_limit_ff   <= csr_wdata[PRESSURE_WIDTH-1:0];
            CFG_VOLUME_LIMIT:     volume_limit_ff     <= csr_wdata[15:0];
            CFG_ASSIST_MODE:      assist_mode_ff      <= csr_wdata[0];
            CFG_ASSIST_THRESHOLD: assist_threshold_ff <= csr_wdata[PRESSURE_WIDTH-1:0];
            CFG_THREE_AXIS:       three_axis_ff       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_tick_ff     <= req_tick;
         in_start_ff    <= req_start_request;
         in_manual_ff   <= req_manual_request;
         in_restart_ff  <= req_restart;
         in_homed1_ff   <= req_axis1_homed;
         in_homed2_ff   <= req_axis2_homed;
         in_homed3_ff   <= req_axis3_homed;
         in_pressure_ff <= req_pressure;
         in_volume_ff   <= req_volume;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_HOMING;
         elapsed_ff   <= '0;
         enable_ff    <= 1'b0;
         white_ff     <= 1'b1;
         red_ff       <= 1'b1;
         running_ff   <= 1'b0;
         cmd1_ff      <= CMD_NONE;
         cmd23_ff     <= CMD_NONE;
         vclear_ff    <= 1'b0;
      end else begin
         if (req_accept) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            phase_ff     <= phase_in;
            elapsed_ff   <= elapsed_in;
            enable_ff    <= enable_in;
            white_ff     <= white_in;
            red_ff       <= red_in;
            running_ff   <= running_in;
            cmd1_ff      <= cmd1_in;
            cmd23_ff     <= cmd23_in;
            vclear_ff    <= vclear_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_phase              = phase_ff;
   assign rsp_axis1_command      = cmd1_ff;
   assign rsp_other_axes_command = cmd23_ff;
   assign rsp_driver_enable      = enable_ff;
   assign rsp_white_led          = white_ff;
   assign rsp_red_led            = red_ff;
   assign rsp_volume_clear       = vclear_ff;
   assign rsp_running            = running_ff;

   `BCS_ASSERT_NEXT(a_restart_homes, clock, reset, advance && in_restart_ff,
      rsp_valid && rsp_phase == PH_HOMING && rsp_axis1_command == CMD_HOME &&
      rsp_other_axes_command == CMD_HOME, "Restart did not command homing.")
   `BCS_ASSERT_NOW(a_vclear_phase, clock, reset, rsp_valid && rsp_volume_clear,
      rsp_phase == PH_EXHALE_START || rsp_phase == PH_STOPPED,
      "Volume clear outside the end of hold.")
   `BCS_ASSERT_NOW(a_hold_cmd, clock, reset,
      rsp_valid && rsp_axis1_command == CMD_HOLD,
      rsp_other_axes_command == CMD_HOLD && rsp_phase == PH_HOLDING,
      "Hold command issued outside the hold start.")
   `BCS_ASSERT_NOW(a_stall_only_full, clock, reset, req_stall,
      rsp_valid && rsp_stall, "Request stalled while the result register was free.")

endmodule

/* sim/tb_breath_cycle_sequencer.sv */
// Testbench for breath_cycle_sequencer: directed and random requests, each result checked
// against an in-line model of the phase sequencer, with random idling on both channels.
// Depends on bcs_pkg and the breath_cycle_sequencer RTL.
module tb_breath_cycle_sequencer;
   timeunit 1ns;
   timeprecision 1ps;

   import bcs_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct {
      logic                tick;
      logic                start_req;
      logic                manual_req;
      logic                restart;
      logic         [2:0]  homed;
      logic signed  [15:0] pressure;
      logic         [15:0] volume;
   } breath_sample_type;

   typedef struct {
      phase_type phase;
      cmd_type   axis1_cmd;
      cmd_type   other_cmd;
      logic      enable;
      logic      white;
      logic      red;
      logic      vclear;
      logic      running;
   } breath_status_type;

   typedef struct {
      logic        [15:0] rise;
      logic        [15:0] hold_high;
      logic        [15:0] hold_low;
      logic signed [15:0] pressure_limit;
      logic        [15:0] volume_limit;
      logic               assist;
      logic signed [15:0] assist_threshold;
      logic               three_axis;
   } seq_settings_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_tick = 1'b0;
   logic               req_start_request = 1'b0;
   logic               req_manual_request = 1'b0;
   logic               req_restart = 1'b0;
   logic               req_axis1_homed = 1'b0;
   logic               req_axis2_homed = 1'b0;
   logic               req_axis3_homed = 1'b0;
   logic signed [15:0] req_pressure = '0;
   logic        [15:0] req_volume = '0;

   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [3:0] rsp_phase;
   logic [2:0] rsp_axis1_command;
   logic [2:0] rsp_other_axes_command;
   logic       rsp_driver_enable;
   logic       rsp_white_led;
   logic       rsp_red_led;
   logic       rsp_volume_clear;
   logic       rsp_running;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   seq_settings_type cfg;
   phase_type        st_phase;
   logic      [15:0] st_elapsed;
   logic             st_enable;
   logic             st_white;
   logic             st_red;
   logic             st_running;

   breath_status_type pending_status[$];
   bit                idle_on = 1'b1;
   int                rsp_hold_cycles = 0;
   int                error_count = 0;
   int                requests_sent = 0;
   int                results_checked = 0;
   int                settings_count = 0;

   breath_cycle_sequencer u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_tick               (req_tick),
      .req_start_request      (req_start_request),
      .req_manual_request     (req_manual_request),
      .req_restart            (req_restart),
      .req_axis1_homed        (req_axis1_homed),
      .req_axis2_homed        (req_axis2_homed),
      .req_axis3_homed        (req_axis3_homed),
      .req_pressure           (req_pressure),
      .req_volume             (req_volume),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_phase              (rsp_phase),
      .rsp_axis1_command      (rsp_axis1_command),
      .rsp_other_axes_command (rsp_other_axes_command),
      .rsp_driver_enable      (rsp_driver_enable),
      .rsp_white_led          (rsp_white_led),
      .rsp_red_led            (rsp_red_led),
      .rsp_volume_clear       (rsp_volume_clear),
      .rsp_running            (rsp_running),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic seq_settings_type make_settings(logic [15:0] rise,
                                                      logic [15:0] hold_high,
                                                      logic [15:0] hold_low,
                                                      logic signed [15:0] pressure_limit,
                                                      logic [15:0] volume_limit,
                                                      logic assist,
                                                      logic signed [15:0] assist_threshold,
                                                      logic three_axis);
      seq_settings_type s;
      s.rise             = rise;
      s.hold_high        = hold_high;
      s.hold_low         = hold_low;
      s.pressure_limit   = pressure_limit;
      s.volume_limit     = volume_limit;
      s.assist           = assist;
      s.assist_threshold = assist_threshold;
      s.three_axis       = three_axis;
      return s;
   endfunction

   function automatic void reset_model();
      cfg = make_settings(16'(RISE_TIME_RESET), 16'(HOLD_HIGH_RESET), 16'(HOLD_LOW_RESET),
                          16'(PRESSURE_LIMIT_RESET), 16'(VOLUME_LIMIT_RESET), 1'b0,
                          16'(ASSIST_THRESHOLD_RESET), 1'b1);
      st_phase   = PH_HOMING;
      st_elapsed = '0;
      st_enable  = 1'b0;
      st_white   = 1'b1;
      st_red     = 1'b1;
      st_running = 1'b0;
   endfunction

   function automatic breath_status_type next_breath_status(breath_sample_type r);
      breath_status_type o;
      o.axis1_cmd = CMD_NONE;
      o.other_cmd = CMD_NONE;
      o.vclear    = 1'b0;
      if (r.tick && st_elapsed != 16'hFFFF) st_elapsed++;
      if (r.restart) begin
         st_phase    = PH_HOMING;
         o.axis1_cmd = CMD_HOME;
         o.other_cmd = CMD_HOME;
      end else begin
         case (st_phase)
            PH_STOPPED: begin
               if (r.start_req) begin
                  st_enable  = 1'b1;
                  st_running = 1'b1;
                  st_phase   = PH_RISE_START;
                  st_elapsed = '0;
               end else begin
                  st_running = 1'b0;
               end
               if (r.manual_req) begin
                  st_phase  = PH_MANUAL;
                  st_enable = 1'b1;
               end
            end
            PH_RISE_START: begin
               o.axis1_cmd = cfg.three_axis ? CMD_LOWER : CMD_RAISE;
               o.other_cmd = CMD_LOWER;
               st_elapsed  = '0;
               st_phase    = PH_RISING;
            end
            PH_RISING: begin
               if (st_elapsed >= cfg.rise) begin
                  st_white = 1'b0;
                  st_red   = 1'b0;
                  st_phase = PH_HOLD_START;
               end
               if (r.pressure >= cfg.pressure_limit || r.volume >= cfg.volume_limit)
                  st_phase = PH_HOLD_START;
               if (!r.start_req) begin
                  st_phase  = PH_STOPPED;
                  st_enable = 1'b0;
               end
            end
            PH_HOLD_START: begin
               o.axis1_cmd = CMD_HOLD;
               o.other_cmd = CMD_HOLD;
               st_elapsed  = '0;
               st_phase    = PH_HOLDING;
            end
            PH_HOLDING: begin
               if (st_elapsed >= cfg.hold_high) begin
                  o.vclear = 1'b1;
                  st_phase = PH_EXHALE_START;
               end
               if (!r.start_req) begin
                  st_phase  = PH_STOPPED;
                  st_enable = 1'b0;
               end
            end
            PH_EXHALE_START: begin
               o.axis1_cmd = cfg.three_axis ? CMD_RAISE : CMD_LOWER;
               o.other_cmd = CMD_RAISE;
               st_elapsed  = '0;
               st_phase    = PH_EXHALING;
            end
            PH_EXHALING: begin
               if (cfg.assist) begin
                  if (st_elapsed >= (cfg.hold_low >> 1) && r.pressure < cfg.assist_threshold) begin
                     st_elapsed = '0;
                     st_phase   = PH_RISE_START;
                  end
               end else if (st_elapsed >= cfg.hold_low) begin
                  st_red     = 1'b1;
                  st_elapsed = '0;
                  st_phase   = PH_RISE_START;
               end
               if (!r.start_req) begin
                  st_phase  = PH_STOPPED;
                  st_enable = 1'b0;
               end
            end
            PH_MANUAL: begin
               if (!r.manual_req) begin
                  st_phase  = PH_STOPPED;
                  st_enable = 1'b0;
               end
            end
            default: begin
               st_phase  = PH_HOMING;
               st_enable = 1'b1;
               if (cfg.three_axis) begin
                  if (&r.homed) st_phase = PH_STOPPED;
               end else if (r.homed[0]) begin
                  o.axis1_cmd = CMD_LOWER;
                  st_phase    = PH_STOPPED;
               end
            end
         endcase
      end
      o.phase   = st_phase;
      o.enable  = st_enable;
      o.white   = st_white;
      o.red     = st_red;
      o.running = st_running;
      return o;
   endfunction

   function automatic breath_sample_type breath_sample(logic tick, logic start_req,
                                                       logic manual_req, logic restart,
                                                       logic [2:0] homed,
                                                       logic signed [15:0] pressure,
                                                       logic [15:0] volume);
      breath_sample_type r;
      r.tick       = tick;
      r.start_req  = start_req;
      r.manual_req = manual_req;
      r.restart    = restart;
      r.homed      = homed;
      r.pressure   = pressure;
      r.volume     = volume;
      return r;
   endfunction

   function automatic breath_sample_type random_breath();
      breath_sample_type r;
      if ($urandom_range(0, 9) == 0) begin
         {r.tick, r.start_req, r.manual_req, r.restart, r.homed} = 7'($urandom);
         r.pressure = 16'($urandom);
         r.volume   = 16'($urandom);
      end else begin
         r.tick       = ($urandom_range(0, 3) != 0);
         r.start_req  = ($urandom_range(0, 24) != 0);
         r.manual_req = ($urandom_range(0, 29) == 0);
         r.restart    = ($urandom_range(0, 99) == 0);
         for (int k = 0; k < 3; k++) r.homed[k] = ($urandom_range(0, 9) != 0);
         case ($urandom_range(0, 9))
            0:       r.pressure = 16'($urandom);
            1, 2:    r.pressure = cfg.pressure_limit + 16'($urandom_range(0, 6)) - 16'd3;
            3, 4:    r.pressure = cfg.assist_threshold + 16'($urandom_range(0, 6)) - 16'd3;
            default: r.pressure = 16'($urandom_range(0, 300)) - 16'd100;
         endcase
         case ($urandom_range(0, 7))
            0:       r.volume = 16'($urandom);
            1, 2:    r.volume = cfg.volume_limit + 16'($urandom_range(0, 6)) - 16'd3;
            default: r.volume = 16'($urandom_range(0, 300));
         endcase
      end
      return r;
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   task automatic send_breath(breath_sample_type r);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_tick           <= r.tick;
      req_start_request  <= r.start_req;
      req_manual_request <= r.manual_req;
      req_restart        <= r.restart;
      req_axis1_homed    <= r.homed[0];
      req_axis2_homed    <= r.homed[1];
      req_axis3_homed    <= r.homed[2];
      req_pressure       <= r.pressure;
      req_volume         <= r.volume;
      do @(posedge clock); while (req_stall);
      pending_status.push_back(next_breath_status(r));
      requests_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(cfg_index_type idx, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_settings(seq_settings_type s);
      drain_results();
      write_reg(CFG_RISE_TIME, s.rise);
      write_reg(CFG_HOLD_HIGH, s.hold_high);
      write_reg(CFG_HOLD_LOW, s.hold_low);
      write_reg(CFG_PRESSURE_LIMIT, s.pressure_limit);
      write_reg(CFG_VOLUME_LIMIT, s.volume_limit);
      write_reg(CFG_ASSIST_MODE, {15'd0, s.assist});
      write_reg(CFG_ASSIST_THRESHOLD, s.assist_threshold);
      write_reg(CFG_THREE_AXIS, {15'd0, s.three_axis});
      csr_valid <= 1'b0;
      cfg = s;
      settings_count++;
   endtask

   task automatic test_homing();
      send_breath(breath_sample(1'b1, 1'b0, 1'b0, 1'b0, 3'b011, 16'sd0, 16'd0));
      send_breath(breath_sample(1'b0, 1'b1, 1'b1, 1'b0, 3'b111, 16'sd0, 16'd0));
      send_breath(breath_sample(1'b1, 1'b1, 1'b1, 1'b1, 3'b111, 16'h8000, 16'hFFFF));
      apply_settings(make_settings(16'd2, 16'd1, 16'd3, 16'sd1000, 16'd400, 1'b0,
                                   -16'sd30, 1'b0));
      send_breath(breath_sample(1'b1, 1'b0, 1'b0, 1'b0, 3'b110, 16'sd0, 16'd0));
      send_breath(breath_sample(1'b1, 1'b0, 1'b0, 1'b0, 3'b001, 16'sd0, 16'd0));
   endtask

   task automatic test_stopped_requests();
      send_breath(breath_sample(1'b1, 1'b1, 1'b1, 1'b0, 3'b111, 16'sd0, 16'd0));
      send_breath(breath_sample(1'b1, 1'b0, 1'b1, 1'b0, 3'b111, 16'sd0, 16'd0));
      send_breath(breath_sample(1'b1, 1'b0, 1'b0, 1'b0, 3'b111, 16'sd0, 16'd0));
      send_breath(breath_sample(1'b1, 1'b0, 1'b0, 1'b0, 3'b111, 16'sd0, 16'd0));
   endtask

   // The rise below times out on the same request that hits the pressure limit; the
   // second rise ends on volume alone, and the final hold loses its start request as
   // the hold time runs out.
   task automatic test_breath_cycle();
      send_breath(breath_sample(1'b1, 1'b1, 1'b0, 1'b0, 3'b111, 16'sd0, 16'd0));
      send_breath(breath_sample(1'b1, 1'b1, 1'b0, 1'b0, 3'b111, 16'sd0, 16'd0));
      send_breath(breath_sample(1'b1, 1'b1, 1'b0, 1'b0, 3'b111, 16'sd100, 16'd0));
      send_breath(breath_sample(1'b1, 1'b1, 1'b0, 1'b0, 3'b111, 16'h7FFF, 16'd0));
      send_breath(breath_sample(1'b1, 1'b1, 1'b0, 1'b0, 3'b111, 16'sd0, 16'd0));
      send_breath(breath_sample(1'b1, 1'b1, 1'b0, 1'b0, 3'b111, 16'sd0, 16'd0));
      send_breath(breath_sample(1'b1, 1'b1, 1'b0, 1'b0, 3'b111, 16'sd0, 16'd0));
      repeat (3) send_breath(breath_sample(1'b1, 1'b1, 1'b0, 1'b0, 3'b111, 16'sd0, 16'd0));
      send_breath(breath_sample(1'b1, 1'b1, 1'b0, 1'b0, 3'b111, 16'sd0, 16'd0));
      send_breath(breath_sample(1'b0, 1'b1, 1'b0, 1'b0, 3'b111, 16'h8000, 16'hFFFF));
      send_breath(breath_sample(1'b1, 1'b1, 1'b0, 1'b0, 3'b111, 16'sd0, 16'd0));
      send_breath(breath_sample(1'b1, 1'b0, 1'b0, 1'b0, 3'b111, 16'sd0, 16'd0));
   endtask

   // Assisted exhale with an odd low time: low pressure is ignored until the elapsed
   // time reaches half the low time, rounded down, and then starts the next breath.
   task automatic test_assist_half_time();
      apply_settings(make_settings(16'd0, 16'd0, 16'd201, 16'h7FFF, 16'hFFFF, 1'b1,
                                   -16'sd30, 1'b1));
      idle_on = 1'b0;
      send_breath(breath_sample(1'b0, 1'b0, 1'b0, 1'b1, 3'b000, 16'sd0, 16'd0));
      send_breath(breath_sample(1'b0, 1'b0, 1'b0, 1'b0, 3'b111, 16'sd0, 16'd0));
      repeat (6) send_breath(breath_sample(1'b1, 1'b1, 1'b0, 1'b0, 3'b111, 16'sd0, 16'd0));
      repeat (99) send_breath(breath_sample(1'b1, 1'b1, 1'b0, 1'b0, 3'b111, -16'sd31, 16'd0));
      send_breath(breath_sample(1'b1, 1'b1, 1'b0, 1'b0, 3'b111, -16'sd31, 16'd0));
      idle_on = 1'b1;
   endtask

   task automatic test_random_breaths(seq_settings_type s, int count, bit with_idle);
      apply_settings(s);
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) idle_on = with_idle && ($urandom_range(0, 3) != 0);
         send_breath(random_breath());
      end
   endtask

   task automatic test_output_backpressure();
      apply_settings(make_settings(16'd8, 16'd5, 16'd9, 16'sd300, 16'd400, 1'b0,
                                   -16'sd30, 1'b1));
      idle_on         = 1'b0;
      rsp_hold_cycles = 150;
      repeat (40) send_breath(random_breath());
      idle_on = 1'b1;
   endtask

   initial begin : rsp_stall_gen
      int burst;
      burst = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles != 0) begin
            rsp_stall <= 1'b1;
            rsp_hold_cycles--;
         end else if (burst != 0) begin
            rsp_stall <= 1'b1;
            burst--;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(0, 16);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : status_check
      breath_status_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_status.size() == 0) begin
            $error("result with no request waiting: phase %0d", rsp_phase);
            error_count++;
         end else begin
            want = pending_status.pop_front();
            results_checked++;
            check_field("phase", want.phase, rsp_phase);
            check_field("axis1_command", want.axis1_cmd, rsp_axis1_command);
            check_field("other_axes_command", want.other_cmd, rsp_other_axes_command);
            check_field("driver_enable", want.enable, rsp_driver_enable);
            check_field("white_led", want.white, rsp_white_led);
            check_field("red_led", want.red, rsp_red_led);
            check_field("volume_clear", want.vclear, rsp_volume_clear);
            check_field("running", want.running, rsp_running);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      reset_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_homing();
      test_stopped_requests();
      test_breath_cycle();
      test_assist_half_time();
      test_random_breaths(make_settings(16'd8, 16'd5, 16'd9, 16'sd300, 16'd400, 1'b0,
                                        -16'sd30, 1'b1), 250, 1'b1);
      test_random_breaths(make_settings(16'd6, 16'd4, 16'd11, 16'sd250, 16'd350, 1'b1,
                                        16'sd0, 1'b0), 200, 1'b1);
      test_random_breaths(make_settings(16'd0, 16'd0, 16'd0, 16'h8000, 16'd0, 1'b1,
                                        16'h7FFF, 1'b0), 80, 1'b1);
      test_random_breaths(make_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'hFFFF,
                                        1'b0, 16'h8000, 1'b1), 80, 1'b1);
      test_output_backpressure();
      test_random_breaths(make_settings(16'd5, 16'd3, 16'd7, 16'sd200, 16'd300, 1'b1,
                                        -16'sd20, 1'b1), 150, 1'b0);
      drain_results();
      repeat (4) @(posedge clock);
      $display("Sent %0d requests and checked %0d results under %0d register settings,",
               requests_sent, results_checked, settings_count);
      $display("covering homing, manual, timed and assisted breaths, the assist half time"
               , " and output backpressure.");
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* breath_cycle_sequencer.f */
+incdir+sv
sv/bcs_pkg.sv
sv/breath_cycle_sequencer.sv
sim/tb_breath_cycle_sequencer.sv
